[rtl/bole_pkg.sv]
// ----------------------------------------------------------------------------
// bole_pkg
// Shared codes and types of the bounded ordered list engine: action codes,
// result status codes and the control word broadcast to the cell chain.
// ----------------------------------------------------------------------------
package bole_pkg;

    localparam int VALUE_W  = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 9;

    localparam logic [ACTION_W-1:0] ACT_INSERT_FRONT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE_BACK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE_POS   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SEARCH       = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // Operation broadcast to every cell in the cycle an item is accepted.
    typedef struct packed {
        logic insert;
        logic remove;
        logic search;
    } cell_ctrl_t;

endpackage

[rtl/bole_cell.sv]
// ----------------------------------------------------------------------------
// bole_cell
// One slot of the list. Holds one entry, takes its left neighbor's entry on
// an insert at the front, takes its right neighbor's entry when a delete
// closes a gap at or in front of it, and registers its search match.
// ----------------------------------------------------------------------------
module bole_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 9
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bole_pkg::cell_ctrl_t          ctrl,
    input  logic [CNT_W-1:0]              del_first,
    input  logic [CNT_W-1:0]              count,
    input  logic [bole_pkg::VALUE_W-1:0]  key,
    input  logic [bole_pkg::VALUE_W-1:0]  left_data,
    input  logic [bole_pkg::VALUE_W-1:0]  right_data,
    output logic [bole_pkg::VALUE_W-1:0]  data,
    output logic                          match
);

    logic [bole_pkg::VALUE_W-1:0] data_reg;
    logic [bole_pkg::VALUE_W-1:0] data_next;
    logic                         match_reg;
    logic                         match_next;
    logic                         live;
    logic                         in_gap_tail;

    assign live        = CNT_W'(INDEX) < count;
    assign in_gap_tail = CNT_W'(INDEX) >= del_first;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.insert)
        begin
            data_next = left_data;
        end
        else if (ctrl.remove && in_gap_tail)
        begin
            data_next = right_data;
        end
        match_next = ctrl.search && live && (data_reg == key);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

[rtl/bole_match_tree.sv]
// ----------------------------------------------------------------------------
// bole_match_tree
// Registered OR reduction of the per-cell match bits. Bits are folded in
// groups of sixteen into group registers; the final OR of the groups is
// left to the caller's output register.
// ----------------------------------------------------------------------------
module bole_match_tree #(
    parameter int N = 256
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  logic [N-1:0] match,
    output logic         any
);

    localparam int GROUP = 16;
    localparam int NG    = (N + GROUP - 1) / GROUP;

    logic [NG*GROUP-1:0] padded;
    logic [NG-1:0]       group_reg;
    logic [NG-1:0]       group_next;

    always_comb
    begin
        padded = '0;
        padded[N-1:0] = match;
        for (int g = 0; g < NG; g++)
        begin
            group_next[g] = |padded[g*GROUP +: GROUP];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_reg <= '0;
        end
        else if (load)
        begin
            group_reg <= group_next;
        end
    end

    assign any = |group_reg;

endmodule

[rtl/bounded_ordered_list_engine_top.sv]
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top
// Ordered list of up to CAPACITY 32-bit values held in a chain of cells,
// with insert at the front, delete at the back, delete at a position and
// search.
// ----------------------------------------------------------------------------
// Each operation runs from the input beat to the result in steps: the cells
// shift and compare in the cycle the beat is taken, the match bits are then
// folded through one registered group stage, and the final OR lands in the
// output register, which waits while the output side stalls. A new input beat
// is taken only once the result has moved into the output register, so one
// operation is in flight at a time. Every input beat yields exactly one result
// beat carrying status, found and the count after the operation. Entries come
// out of reset undefined; only live entries are ever compared, so no clearing
// pass is needed.
module bounded_ordered_list_engine_top #(
    parameter int CAPACITY = 256,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bole_pkg::ACTION_W-1:0]       action,
    input  logic signed [bole_pkg::VALUE_W-1:0] value,
    input  logic [bole_pkg::POS_W-1:0]          position,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bole_pkg::STATUS_W-1:0]       status,
    output logic                                found,
    output logic [CNT_W-1:0]                    count
);

    localparam int CMP_W = (CNT_W > bole_pkg::POS_W) ? CNT_W : bole_pkg::POS_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_GRP  = 2'd1;
    localparam logic [1:0] S_RED  = 2'd2;

    logic [1:0]                    state_reg;
    logic [1:0]                    state_next;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              count_next;
    logic [bole_pkg::STATUS_W-1:0] pend_status_reg;
    logic [bole_pkg::STATUS_W-1:0] pend_status_next;
    logic                          pend_search_reg;
    logic                          pend_search_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [bole_pkg::STATUS_W-1:0] status_reg;
    logic                          found_reg;
    logic [CNT_W-1:0]              count_out_reg;

    logic                          accept;
    logic                          out_load;
    logic                          full;
    logic                          pos_ok;
    logic [CMP_W-1:0]              pos_ext;
    logic [CMP_W-1:0]              cnt_ext;
    logic [CNT_W-1:0]              del_first;
    bole_pkg::cell_ctrl_t          ctrl;
    logic [bole_pkg::VALUE_W-1:0]  key;
    logic                          any_match;

    logic [bole_pkg::VALUE_W-1:0]  cell_data [CAPACITY];
    logic [CAPACITY-1:0]           cell_match;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign out_load = (state_reg == S_RED) && (!out_valid_reg || !out_stall);

    assign key       = $unsigned(value);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign pos_ext   = CMP_W'(position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign pos_ok    = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign del_first = CNT_W'(pos_ext - CMP_W'(1));

    always_comb
    begin
        ctrl             = '0;
        count_next       = count_reg;
        pend_status_next = pend_status_reg;
        pend_search_next = pend_search_reg;
        if (accept)
        begin
            pend_status_next = bole_pkg::ST_OK;
            pend_search_next = 1'b0;
            case (action)
                bole_pkg::ACT_INSERT_FRONT:
                begin
                    if (full)
                    begin
                        pend_status_next = bole_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctrl.insert = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                bole_pkg::ACT_DELETE_BACK:
                begin
                    if (count_reg == '0)
                    begin
                        pend_status_next = bole_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                bole_pkg::ACT_DELETE_POS:
                begin
                    if (!pos_ok)
                    begin
                        pend_status_next = bole_pkg::ST_BADPOS;
                    end
                    else
                    begin
                        ctrl.remove = 1'b1;
                        count_next  = count_reg - CNT_W'(1);
                    end
                end
                bole_pkg::ACT_SEARCH:
                begin
                    ctrl.search      = 1'b1;
                    pend_search_next = 1'b1;
                end
                default:
                begin
                    pend_status_next = bole_pkg::ST_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_GRP;
                end
            end
            S_GRP:
            begin
                state_next = S_RED;
            end
            S_RED:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            pend_status_reg <= bole_pkg::ST_OK;
            pend_search_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            out_valid_reg   <= out_valid_next;
            pend_status_reg <= pend_status_next;
            pend_search_reg <= pend_search_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg    <= pend_status_reg;
            found_reg     <= pend_search_reg && any_match;
            count_out_reg <= count_reg;
        end
    end

    // Cell 0 takes the new value on an insert; the back cell refills from
    // itself on a delete, since that slot falls out of the live range.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [bole_pkg::VALUE_W-1:0] left_data;
        logic [bole_pkg::VALUE_W-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = key;
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[i+1];
        end

        bole_cell #(
            .INDEX (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .del_first  (del_first),
            .count      (count_reg),
            .key        (key),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i]),
            .match      (cell_match[i])
        );
    end

    bole_match_tree #(
        .N (CAPACITY)
    ) u_match_tree (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (state_reg == S_GRP),
        .match (cell_match),
        .any   (any_match)
    );

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign found     = found_reg;
    assign count     = count_out_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count exceeds capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (action == bole_pkg::ACT_INSERT_FRONT) && !full
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the count by one");

    a_search_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (action == bole_pkg::ACT_SEARCH) |=> $stable(count_reg))
        else $error("search changed the count");

    a_result_from_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_RED)
        else $error("result appeared outside the reduce step");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> status == bole_pkg::ST_OK)
        else $error("found set with a failing status");
`endif

endmodule

[tb/bounded_ordered_list_engine_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_top_tb
// Drives insert, delete and search beats into the list engine with random
// idle and stall on both sides. It keeps a shadow copy of the list to work
// out the status, found flag and count of every result beat, then compares
// each result beat in order against that prediction.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_top_tb;

    localparam int CAPACITY     = 256;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int POS_MAX      = (1 << bole_pkg::POS_W) - 1;
    localparam int MAX_WAIT     = 11;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_ITEMS = 1150;

    typedef struct packed {
        logic [bole_pkg::STATUS_W-1:0] status;
        logic                          found;
        logic [CNT_W-1:0]              count;
    } list_result_t;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_stall;
    logic [bole_pkg::ACTION_W-1:0]       action;
    logic signed [bole_pkg::VALUE_W-1:0] value;
    logic [bole_pkg::POS_W-1:0]          position;
    logic                                out_valid;
    logic                                out_stall;
    logic [bole_pkg::STATUS_W-1:0]       status;
    logic                                found;
    logic [CNT_W-1:0]                    count;

    list_result_t                 pending_results [$];
    logic [bole_pkg::VALUE_W-1:0] shadow_list [$];
    bit                           no_idle;
    int                           error_count;
    int                           idle_cycles;
    int                           ops_by_action [4];
    int                           full_hits;
    int                           empty_hits;
    int                           badpos_hits;
    int                           found_hits;
    int                           results_checked;

    bounded_ordered_list_engine_top #(
        .CAPACITY (CAPACITY)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .value     (value),
        .position  (position),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .found     (found),
        .count     (count)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic int draw_wait();
        if (no_idle)
        begin
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic [bole_pkg::POS_W-1:0] to_pos(input int p);
        return p[bole_pkg::POS_W-1:0];
    endfunction

    // Applies one operation to the shadow list and returns the result beat
    // the engine should produce for it.
    function automatic list_result_t predict_list_result(
        input logic [bole_pkg::ACTION_W-1:0] op,
        input logic [bole_pkg::VALUE_W-1:0]  val,
        input logic [bole_pkg::POS_W-1:0]    pos
    );
        list_result_t r;
        r.status = bole_pkg::ST_OK;
        r.found  = 1'b0;
        case (op)
            bole_pkg::ACT_INSERT_FRONT:
            begin
                if (shadow_list.size() >= CAPACITY)
                begin
                    r.status = bole_pkg::ST_FULL;
                end
                else
                begin
                    shadow_list.push_front(val);
                end
            end
            bole_pkg::ACT_DELETE_BACK:
            begin
                if (shadow_list.size() == 0)
                begin
                    r.status = bole_pkg::ST_EMPTY;
                end
                else
                begin
                    void'(shadow_list.pop_back());
                end
            end
            bole_pkg::ACT_DELETE_POS:
            begin
                if (pos == 0 || int'(pos) > shadow_list.size())
                begin
                    r.status = bole_pkg::ST_BADPOS;
                end
                else
                begin
                    shadow_list.delete(int'(pos) - 1);
                end
            end
            default:
            begin
                foreach (shadow_list[i])
                begin
                    if (shadow_list[i] == val)
                    begin
                        r.found = 1'b1;
                    end
                end
            end
        endcase
        r.count = CNT_W'(shadow_list.size());
        return r;
    endfunction

    function automatic logic [bole_pkg::VALUE_W-1:0] pick_value(input bit prefer_live);
        int k;
        k = $urandom_range(0, 7);
        if (prefer_live && shadow_list.size() != 0 && k < 4)
        begin
            return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
        end
        if (k == 7)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Mostly live positions, with zero, one past the back and anything in
    // the field's range mixed in.
    function automatic logic [bole_pkg::POS_W-1:0] pick_position();
        int k;
        int n;
        n = shadow_list.size();
        k = $urandom_range(0, 9);
        if (n != 0 && k < 7)
        begin
            return to_pos($urandom_range(1, n));
        end
        if (k == 7)
        begin
            return '0;
        end
        if (k == 8 && n < POS_MAX)
        begin
            return to_pos(n + 1);
        end
        return to_pos($urandom_range(0, POS_MAX));
    endfunction

    // Called at a rising edge; returns at the edge the beat is taken, with
    // valid still high so a back-to-back beat needs no second assignment.
    task automatic send_list_op(
        input logic [bole_pkg::ACTION_W-1:0] op,
        input logic [bole_pkg::VALUE_W-1:0]  val,
        input logic [bole_pkg::POS_W-1:0]    pos
    );
        int           gap;
        list_result_t r;
        gap = draw_wait();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        action   <= op;
        value    <= val;
        position <= pos;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall !== 1'b0) @(posedge clk);
        r = predict_list_result(op, val, pos);
        pending_results.push_back(r);
        ops_by_action[op]++;
        case (r.status)
            bole_pkg::ST_FULL:   full_hits++;
            bole_pkg::ST_EMPTY:  empty_hits++;
            bole_pkg::ST_BADPOS: badpos_hits++;
            default:   ;
        endcase
        if (r.found)
        begin
            found_hits++;
        end
    endtask

    task automatic test_empty_list();
        no_idle = 1'b0;
        send_list_op(bole_pkg::ACT_DELETE_BACK, $urandom, to_pos($urandom_range(0, POS_MAX)));
        send_list_op(bole_pkg::ACT_DELETE_POS, $urandom, '0);
        send_list_op(bole_pkg::ACT_DELETE_POS, $urandom, to_pos(1));
        send_list_op(bole_pkg::ACT_DELETE_POS, $urandom, to_pos(POS_MAX));
        send_list_op(bole_pkg::ACT_SEARCH, 32'h0000_0000, to_pos($urandom_range(0, POS_MAX)));
        send_list_op(bole_pkg::ACT_SEARCH, 32'hFFFF_FFFF, to_pos($urandom_range(0, POS_MAX)));
    endtask

    task automatic test_edge_values();
        send_list_op(bole_pkg::ACT_INSERT_FRONT, 32'h8000_0000, '0);
        send_list_op(bole_pkg::ACT_INSERT_FRONT, 32'h7FFF_FFFF, to_pos(POS_MAX));
        send_list_op(bole_pkg::ACT_INSERT_FRONT, 32'h0000_0000, '0);
        send_list_op(bole_pkg::ACT_INSERT_FRONT, 32'hFFFF_FFFF, to_pos(POS_MAX));
        send_list_op(bole_pkg::ACT_SEARCH, 32'h8000_0000, '0);
        send_list_op(bole_pkg::ACT_SEARCH, 32'hFFFF_FFFF, '0);
        send_list_op(bole_pkg::ACT_SEARCH, 32'h7FFF_FFFF, '0);
        send_list_op(bole_pkg::ACT_SEARCH, 32'h1234_5678, '0);
        send_list_op(bole_pkg::ACT_DELETE_POS, '0, to_pos(5));
        send_list_op(bole_pkg::ACT_DELETE_POS, '0, '0);
        send_list_op(bole_pkg::ACT_DELETE_POS, '0, to_pos(POS_MAX));
        // Middle entry, then back, then front.
        send_list_op(bole_pkg::ACT_DELETE_POS, '0, to_pos(2));
        send_list_op(bole_pkg::ACT_SEARCH, 32'h0000_0000, '0);
        send_list_op(bole_pkg::ACT_DELETE_POS, '0, to_pos(3));
        send_list_op(bole_pkg::ACT_DELETE_POS, '0, to_pos(1));
        send_list_op(bole_pkg::ACT_DELETE_BACK, '0, '0);
        send_list_op(bole_pkg::ACT_DELETE_BACK, '0, '0);
    endtask

    task automatic test_fill_to_capacity();
        no_idle = 1'b1;
        while (shadow_list.size() < CAPACITY)
        begin
            send_list_op(bole_pkg::ACT_INSERT_FRONT, $urandom,
                         to_pos($urandom_range(0, POS_MAX)));
        end
        no_idle = 1'b0;
        send_list_op(bole_pkg::ACT_INSERT_FRONT, $urandom, '0);
        send_list_op(bole_pkg::ACT_INSERT_FRONT, 32'h8000_0000, '0);
        send_list_op(bole_pkg::ACT_SEARCH, shadow_list[CAPACITY - 1], '0);
        send_list_op(bole_pkg::ACT_SEARCH, shadow_list[0], '0);
        send_list_op(bole_pkg::ACT_DELETE_POS, '0, to_pos(CAPACITY + 1));
        send_list_op(bole_pkg::ACT_DELETE_POS, '0, to_pos(CAPACITY));
        send_list_op(bole_pkg::ACT_INSERT_FRONT, $urandom, '0);
        send_list_op(bole_pkg::ACT_INSERT_FRONT, $urandom, '0);
        send_list_op(bole_pkg::ACT_DELETE_BACK, '0, '0);
        send_list_op(bole_pkg::ACT_DELETE_POS, '0, to_pos(CAPACITY / 2));
    endtask

    // Phases lean toward filling, draining or neither, so the count sweeps
    // between empty and full several times.
    task automatic test_random_traffic(input int n_items);
        int                            sent;
        int                            phase_len;
        int                            insert_pct;
        logic [bole_pkg::ACTION_W-1:0] op;
        sent = 0;
        while (sent < n_items)
        begin
            phase_len = $urandom_range(40, 160);
            case ($urandom_range(0, 2))
                0:       insert_pct = 85;
                1:       insert_pct = 15;
                default: insert_pct = 35;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            repeat (phase_len)
            begin
                if ($urandom_range(0, 99) < insert_pct)
                begin
                    op = bole_pkg::ACT_INSERT_FRONT;
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       op = bole_pkg::ACT_DELETE_BACK;
                        1:       op = bole_pkg::ACT_DELETE_POS;
                        default: op = bole_pkg::ACT_SEARCH;
                    endcase
                end
                case (op)
                    bole_pkg::ACT_INSERT_FRONT:
                    begin
                        send_list_op(op, pick_value($urandom_range(0, 7) == 0),
                                     to_pos($urandom_range(0, POS_MAX)));
                    end
                    bole_pkg::ACT_DELETE_POS:
                    begin
                        send_list_op(op, $urandom, pick_position());
                    end
                    bole_pkg::ACT_SEARCH:
                    begin
                        send_list_op(op, pick_value(1'b1),
                                     to_pos($urandom_range(0, POS_MAX)));
                    end
                    default:
                    begin
                        send_list_op(op, $urandom, to_pos($urandom_range(0, POS_MAX)));
                    end
                endcase
                sent++;
            end
        end
    endtask

    initial
    begin : result_checker
        int           hold;
        list_result_t want;
        out_stall = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            hold = draw_wait();
            if (hold != 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (out_valid !== 1'b1) @(posedge clk);
            results_checked++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with no operation outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, status);
                    error_count++;
                end
                if (found !== want.found)
                begin
                    $error("found: expected %0d, actual %0d", want.found, found);
                    error_count++;
                end
                if (count !== want.count)
                begin
                    $error("count: expected %0d, actual %0d", want.count, count);
                    error_count++;
                end
            end
        end
    end

    // Ends a hung run: counts cycles in which neither side moves a beat.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        action      = bole_pkg::ACT_SEARCH;
        value       = '0;
        position    = '0;
        no_idle     = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_edge_values();
        test_fill_to_capacity();
        test_random_traffic(RANDOM_ITEMS);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d inserts, %0d back deletes, %0d positional deletes, %0d searches.",
                 ops_by_action[bole_pkg::ACT_INSERT_FRONT],
                 ops_by_action[bole_pkg::ACT_DELETE_BACK],
                 ops_by_action[bole_pkg::ACT_DELETE_POS],
                 ops_by_action[bole_pkg::ACT_SEARCH]);
        $display("Checked %0d results: %0d full, %0d empty, %0d bad position, %0d hits.",
                 results_checked, full_hits, empty_hits, badpos_hits, found_hits);
        $display("Mismatches found: %0d.", error_count);
        if (error_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/bole_pkg.sv
rtl/bole_cell.sv
rtl/bole_match_tree.sv
rtl/bounded_ordered_list_engine_top.sv
tb/bounded_ordered_list_engine_top_tb.sv
